>>> hdl/tmwf_pkg.sv
// Shared types and constants for the trimmed mean window filter.
// Used by tmwf_ctrl, tmwf_dp and trimmed_mean_window_filter_core.
package tmwf_pkg;

    localparam int WINDOW_DEF      = 18;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_EXTRA      = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_DRAIN,
        ST_TRIM,
        ST_DIVIDE,
        ST_DONE
    } t_tmwf_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic update;
        logic scan;
        logic trim;
        logic div_step;
        logic load;
    } t_tmwf_cmd;

    // datapath to controller
    typedef struct packed {
        logic will_full;
        logic scan_last;
        logic div_last;
        logic div_pow2;
        logic out_busy;
    } t_tmwf_status;

endpackage

>>> hdl/tmwf_ctrl.sv
// Sequencing state machine for the trimmed mean window filter.
// Depends on tmwf_pkg; drives the command struct of tmwf_dp.
module tmwf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tmwf_pkg::t_tmwf_status i_status,
    output tmwf_pkg::t_tmwf_cmd    o_cmd
);
    import tmwf_pkg::*;

    t_tmwf_state r_state;
    t_tmwf_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.will_full ? ST_SCAN : ST_DONE;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            // last read of the scan lands in min/max here
            ST_DRAIN: begin
                n_state = ST_TRIM;
            end
            ST_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = i_status.div_pow2 ? ST_DONE : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == ST_UPDATE)
        else $error("accepted request did not move to update");

    a_drain_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> $past(r_state) == ST_SCAN)
        else $error("drain entered without a scan");

    a_divide_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && $past(r_state) != ST_DIVIDE) |->
            $past(r_state) == ST_TRIM && !i_status.div_pow2)
        else $error("divider started out of sequence");

endmodule

>>> hdl/tmwf_dp.sv
// Datapath of the trimmed mean window filter: sample ring, running total,
// min/max scan, reciprocal multiplier and output register. Uses tmwf_pkg.
module tmwf_dp #(
    parameter int WINDOW      = tmwf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  tmwf_pkg::t_tmwf_cmd                      i_cmd,
    output tmwf_pkg::t_tmwf_status                   o_status,
    input  logic [SAMPLE_BITS-1:0]                   i_speed_sample,
    input  logic                                     i_out_stall,
    output logic                                     o_out_valid,
    output logic [SAMPLE_BITS+tmwf_pkg::FRAC_EXTRA-1:0] o_filtered_speed,
    output logic                                     o_window_full
);
    import tmwf_pkg::*;

    localparam int AW        = $clog2(WINDOW);
    localparam int CW        = $clog2(WINDOW + 1);
    localparam int TOTAL_W   = SAMPLE_BITS + CW;
    localparam int QW        = SAMPLE_BITS + FRAC_EXTRA;
    localparam int DW        = TOTAL_W + FRAC_EXTRA;
    localparam int DIVISOR   = WINDOW - 2;
    localparam bit DIV_POW2  = (DIVISOR & (DIVISOR - 1)) == 0;
    localparam int DIV_SHIFT = $clog2(DIVISOR);
    // floor(x * RECIP / 2^RSH) equals floor(x / DIVISOR) for every DW-bit x
    localparam int RSH       = DW + DIV_SHIFT;
    localparam int ND        = (DW + 5) / 4;
    localparam int MW        = 4 * ND;
    localparam int PW        = DW + MW;
    localparam int NW        = $clog2(ND);
    localparam logic [63:0]   RECIP_FULL =
        ((64'd1 << RSH) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [AW-1:0]          rd_addr;

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [AW-1:0]          r_slot;
    logic [CW-1:0]          r_fill;
    logic [TOTAL_W-1:0]     r_total;
    logic [AW-1:0]          r_scan_idx;
    logic                   r_rd_valid;
    logic                   r_rd_first;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [SAMPLE_BITS-1:0] r_hi;
    logic [PW-1:0]          r_acc;
    logic [MW-1:0]          r_mult;
    logic [NW-1:0]          r_div_cnt;
    logic                   r_out_valid;
    logic [QW-1:0]          r_out_data;
    logic                   r_out_full;

    logic                   was_full;
    logic [TOTAL_W-1:0]     old_term;
    logic [TOTAL_W-1:0]     trimmed;
    logic [DW-1:0]          dividend;
    logic [DW+3:0]          digit_prod;
    logic [QW-1:0]          quotient;

    assign was_full   = r_fill == CW'(WINDOW);
    assign rd_addr    = i_cmd.scan ? r_scan_idx : r_slot;
    assign old_term   = was_full ? TOTAL_W'(r_rd_data) : '0;
    assign trimmed    = r_total - TOTAL_W'(r_lo) - TOTAL_W'(r_hi);
    assign dividend   = {trimmed, {FRAC_EXTRA{1'b0}}};
    assign digit_prod = (DW + 4)'(dividend) * (DW + 4)'(r_mult[MW-1 -: 4]);
    assign quotient   = DIV_POW2 ? QW'(dividend >> DIV_SHIFT) : r_acc[RSH +: QW];

    // ring memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[r_slot] <= r_sample;
        end
        r_rd_data <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan;
            if (i_cmd.update) begin
                // drop the oldest sample once the window is full
                r_total <= r_total - old_term + TOTAL_W'(r_sample);
                r_slot  <= (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (!was_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_speed_sample;
        end
        if (i_cmd.update) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        if (i_cmd.scan) begin
            r_rd_first <= r_scan_idx == '0;
        end
        if (r_rd_valid) begin
            if (r_rd_first) begin
                r_lo <= r_rd_data;
                r_hi <= r_rd_data;
            end else begin
                if (r_rd_data < r_lo) begin
                    r_lo <= r_rd_data;
                end
                if (r_rd_data > r_hi) begin
                    r_hi <= r_rd_data;
                end
            end
        end
        if (i_cmd.trim) begin
            r_div_cnt <= '0;
            r_acc     <= '0;
            r_mult    <= RECIP;
        end else if (i_cmd.div_step) begin
            // four reciprocal bits a cycle, most significant first
            r_acc     <= {r_acc[PW-5:0], 4'b0000} + PW'(digit_prod);
            r_mult    <= r_mult << 4;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.load) begin
            r_out_full <= was_full;
            r_out_data <= was_full ? quotient : {r_sample, {FRAC_EXTRA{1'b0}}};
        end
    end

    assign o_status.will_full = r_fill >= CW'(WINDOW - 1);
    assign o_status.scan_last = r_scan_idx == AW'(WINDOW - 1);
    assign o_status.div_last  = r_div_cnt == NW'(ND - 1);
    assign o_status.div_pow2  = DIV_POW2;
    assign o_status.out_busy  = r_out_valid && i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_filtered_speed = r_out_data;
    assign o_window_full    = r_out_full;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW) && r_slot <= AW'(WINDOW - 1))
        else $error("fill count or slot out of range");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.trim |-> r_lo <= r_hi)
        else $error("scan left min above max");

    a_trim_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> was_full)
        else $error("scan started before the window filled");

endmodule

>>> hdl/trimmed_mean_window_filter_core.sv
// Top level of the trimmed mean window filter; instantiates tmwf_ctrl and
// tmwf_dp, both built on tmwf_pkg.
//
// Each accepted speed sample yields one result. While fewer than WINDOW
// samples are held, the sample comes back with four zero fraction bits and
// o_window_full low. From then on the result is the mean of the last WINDOW
// samples with one smallest and one largest removed, with four fraction bits,
// truncated. One request is handled at a time. Once the window is full, a
// min/max scan reads the ring through its single read port one entry a
// cycle. When WINDOW - 2 is not a power of two, a multiplication by its
// reciprocal, four bits a cycle, follows the scan. A finished result sits
// in an output register, so a new request is taken while it waits; a
// stalled output holds the block only when the next result is due.
module trimmed_mean_window_filter_core #(
    parameter int WINDOW      = tmwf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = tmwf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic [SAMPLE_BITS-1:0]                      i_speed_sample,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic [SAMPLE_BITS+tmwf_pkg::FRAC_EXTRA-1:0] o_filtered_speed,
    output logic                                        o_window_full
);
    import tmwf_pkg::*;

    t_tmwf_cmd    cmd;
    t_tmwf_status status;

    tmwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tmwf_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_speed_sample   (i_speed_sample),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_filtered_speed (o_filtered_speed),
        .o_window_full    (o_window_full)
    );

endmodule
